FILE: design/utf8_stream_validator_assert.svh
// Assertion macros shared by the checker of utf8_stream_validator.
// Each macro expects clk and rst to be visible where it is used.
`ifndef UTF8_STREAM_VALIDATOR_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define UTF8V_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that must also hold across reset itself.
`define UTF8V_CHECK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/utf8v_pkg.sv
// Shared types and constants for the UTF-8 stream validator.
// Used by the front classifier, the item queue and the back decoder.
package utf8v_pkg;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_NUL,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_BAD
  } byte_class_t;

  // One classified byte as it travels from front to back.
  typedef struct packed {
    byte_class_t cls;
    logic [5:0]  bits;
    logic        last;
  } class_item_t;

  localparam int CODE_W = 21;

  localparam logic [CODE_W-1:0] MAX_CODE = 21'h10FFFF;
  localparam logic [CODE_W-1:0] SURR_LO  = 21'h00D800;
  localparam logic [CODE_W-1:0] SURR_HI  = 21'h00DFFF;

  localparam logic [1:0] MIN_NONE = 2'd0;
  localparam logic [1:0] MIN_2B   = 2'd1;
  localparam logic [1:0] MIN_3B   = 2'd2;
  localparam logic [1:0] MIN_4B   = 2'd3;

  // Smallest code point that a sequence of the given length may encode.
  function automatic logic [CODE_W-1:0] class_minimum(input logic [1:0] cls);
    logic [CODE_W-1:0] res;
    case (cls)
      MIN_2B:  res = 21'h000080;
      MIN_3B:  res = 21'h000800;
      MIN_4B:  res = 21'h010000;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

FILE: design/utf8_stream_validator.sv
// UTF-8 stream validator, top level.
// Input channel (in_valid/in_ready): one string byte per transfer on
//   data_byte, with last_byte set on the final byte of the string.
// Output channel (out_valid/out_ready): one transfer per string, on
//   string_valid, 1 when the string is well-formed UTF-8.
// Throughput: one byte per cycle while the queue has room, set by the decode
//   step in the back end; the queue absorbs short stalls of the verdict register.
// Verdict path: the final byte lands in the queue, and once the bytes ahead
//   of it have drained and the verdict register is free, the back end judges
//   it into the verdict register.
// Reset (rst, synchronous): empties the queue, clears decode state and
//   drops out_valid; in_ready is high the cycle after reset.
// Receiver stall: the verdict holds in its register; bytes behind it keep
//   decoding, and a following final byte waits in the queue. in_ready drops
//   only once QUEUE_DEPTH bytes are waiting.
// Depends on utf8v_pkg, utf8v_front, utf8v_queue and utf8v_back.
module utf8_stream_validator
  import utf8v_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       string_valid
);

  logic        q_full;
  logic        q_push;
  class_item_t q_push_item;
  logic        q_pop;
  logic        q_not_empty;
  class_item_t q_head_item;

  utf8v_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_push_item)
  );

  utf8v_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (q_head_item)
  );

  utf8v_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_not_empty),
    .q_item       (q_head_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .string_valid (string_valid)
  );

endmodule

FILE: design/utf8v_front.sv
// Input side of the UTF-8 stream validator: classifies each byte and
// pushes it into the item queue. Depends on utf8v_pkg.
module utf8v_front
  import utf8v_pkg::*;
(
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        q_full,
  output logic        q_push,
  output class_item_t q_item
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.last = last_byte;
    q_item.bits = data_byte[5:0];
    if (data_byte == 8'h00) begin
      q_item.cls = CLS_NUL;
    end else if (!data_byte[7]) begin
      q_item.cls = CLS_ASCII;
    end else if (data_byte[7:6] == 2'b10) begin
      q_item.cls = CLS_CONT;
    end else if ((data_byte & 8'hE0) == 8'hC0) begin
      q_item.cls  = CLS_LEAD2;
      q_item.bits = {1'b0, data_byte[4:0]};
    end else if ((data_byte & 8'hF0) == 8'hE0) begin
      q_item.cls  = CLS_LEAD3;
      q_item.bits = {2'b00, data_byte[3:0]};
    end else if ((data_byte & 8'hF8) == 8'hF0) begin
      q_item.cls  = CLS_LEAD4;
      q_item.bits = {3'b000, data_byte[2:0]};
    end else begin
      q_item.cls = CLS_BAD;
    end
  end

endmodule

FILE: design/utf8v_queue.sv
// Short FIFO of classified bytes between front and back.
// Depends on utf8v_pkg for the item type.
module utf8v_queue
  import utf8v_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  class_item_t push_item,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output class_item_t head_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  class_item_t   slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head_item = slots[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/utf8v_back.sv
// Decoder side of the UTF-8 stream validator: walks the classified bytes,
// tracks the open sequence and holds the verdict register. Depends on utf8v_pkg.
module utf8v_back
  import utf8v_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  class_item_t q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        string_valid
);

  logic [1:0]        bytes_pending;
  logic [CODE_W-1:0] code_accum;
  logic [1:0]        min_class;
  logic              error_seen;

  logic [1:0]        bytes_pending_next;
  logic [CODE_W-1:0] code_accum_next;
  logic [1:0]        min_class_next;
  logic              error_seen_next;

  logic [CODE_W-1:0] shifted;
  logic [1:0]        pending_dec;
  logic              range_bad;
  logic              verdict;

  // A last byte waits until the verdict register is free; others flow through.
  assign q_pop = q_valid && (!q_item.last || !out_valid || out_ready);

  assign shifted     = {code_accum[CODE_W-7:0], q_item.bits};
  assign pending_dec = bytes_pending - 2'd1;
  assign range_bad   = (shifted < class_minimum(min_class)) || (shifted > MAX_CODE) ||
                       ((shifted >= SURR_LO) && (shifted <= SURR_HI));

  always_comb begin
    bytes_pending_next = bytes_pending;
    code_accum_next    = code_accum;
    min_class_next     = min_class;
    error_seen_next    = error_seen;
    if (!error_seen) begin
      if (bytes_pending == 2'd0) begin
        case (q_item.cls)
          CLS_ASCII: begin
          end
          CLS_LEAD2: begin
            code_accum_next    = CODE_W'(q_item.bits);
            bytes_pending_next = 2'd1;
            min_class_next     = MIN_2B;
          end
          CLS_LEAD3: begin
            code_accum_next    = CODE_W'(q_item.bits);
            bytes_pending_next = 2'd2;
            min_class_next     = MIN_3B;
          end
          CLS_LEAD4: begin
            code_accum_next    = CODE_W'(q_item.bits);
            bytes_pending_next = 2'd3;
            min_class_next     = MIN_4B;
          end
          default: begin
            error_seen_next = 1'b1;
          end
        endcase
      end else if (q_item.cls != CLS_CONT) begin
        error_seen_next = 1'b1;
      end else begin
        bytes_pending_next = pending_dec;
        code_accum_next    = shifted;
        if (pending_dec == 2'd0) begin
          // sequence complete: check overlong, range and surrogates
          error_seen_next = range_bad;
          code_accum_next = '0;
          min_class_next  = MIN_NONE;
        end
      end
    end
    verdict = !(error_seen_next || (bytes_pending_next != 2'd0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= '0;
      code_accum    <= '0;
      min_class     <= MIN_NONE;
      error_seen    <= 1'b0;
    end else if (q_pop) begin
      if (q_item.last) begin
        bytes_pending <= '0;
        code_accum    <= '0;
        min_class     <= MIN_NONE;
        error_seen    <= 1'b0;
      end else begin
        bytes_pending <= bytes_pending_next;
        code_accum    <= code_accum_next;
        min_class     <= min_class_next;
        error_seen    <= error_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && q_item.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      string_valid <= verdict;
    end
  end

endmodule

FILE: design/utf8v_checker.sv
// Port-level checks for utf8_stream_validator, bound to the top level.
// Depends on utf8_stream_validator_assert.svh for the assertion macros.
`include "utf8_stream_validator_assert.svh"

module utf8v_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] data_byte,
  input logic       last_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic       string_valid
);

  // reset empties the queue and drops any pending verdict
  `UTF8V_CHECK_RST(a_reset_clears, rst |=> (!out_valid && in_ready), "reset did not clear block")

  // a stalled verdict holds its value
  `UTF8V_CHECK(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(string_valid)), "verdict changed while stalled")

  // with the verdict register free the back end drains, so the queue frees a slot
  `UTF8V_CHECK(a_in_recovers, !out_valid |=> in_ready, "input stalled with no verdict pending")

endmodule

bind utf8_stream_validator utf8v_checker u_utf8v_checker (.*);

FILE: tb/tb_top.sv
// Self-checking bench for utf8_stream_validator: drives byte strings, predicts
// one well-formedness verdict per string and checks every verdict transfer.
// Depends on utf8v_pkg and the utf8_stream_validator top level.
module tb_top;
  import utf8v_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int SHOW_ERRORS  = 10;

  typedef struct packed {
    logic [7:0] val;
    logic       fin;
  } byte_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       string_valid;

  byte_item_t byte_q[$];
  logic [7:0] str_buf[$];
  logic       verdict_q[$];

  // Decoder state mirrored from the incoming byte stream
  logic [1:0]  cont_left = 2'd0;
  logic [20:0] cp_acc = '0;
  logic [1:0]  seq_min = MIN_NONE;
  logic        bad_seen = 1'b0;

  logic in_taken = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_reqs = 0;
  int   hold_taken = 0;
  int   hold_left = 0;
  int   err_cnt = 0;
  int   bytes_queued = 0;
  int   strings_queued = 0;
  int   verdicts_seen = 0;
  int   valid_seen = 0;

  utf8_stream_validator dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .string_valid (string_valid)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("timeout: %0d verdicts still outstanding", verdict_q.size());
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [20:0] seq_floor(input logic [1:0] cls);
    logic [20:0] lo;
    case (cls)
      MIN_2B:  lo = 21'h000080;
      MIN_3B:  lo = 21'h000800;
      MIN_4B:  lo = 21'h010000;
      default: lo = 21'h000000;
    endcase
    return lo;
  endfunction

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= SHOW_ERRORS) begin
      $display("ERROR: %s", msg);
    end
  endtask

  // Advance the mirrored decoder by one accepted byte; queue a verdict on the final one.
  task automatic judge_byte(input logic [7:0] b, input logic fin);
    if (!bad_seen) begin
      if (cont_left == 2'd0) begin
        if (b == 8'h00) begin
          bad_seen = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          cp_acc = {16'd0, b[4:0]};
          cont_left = 2'd1;
          seq_min = MIN_2B;
        end else if (b[7:4] == 4'b1110) begin
          cp_acc = {17'd0, b[3:0]};
          cont_left = 2'd2;
          seq_min = MIN_3B;
        end else if (b[7:3] == 5'b11110) begin
          cp_acc = {18'd0, b[2:0]};
          cont_left = 2'd3;
          seq_min = MIN_4B;
        end else if (b[7]) begin
          bad_seen = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        bad_seen = 1'b1;
      end else begin
        cp_acc = {cp_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          if (cp_acc < seq_floor(seq_min) || cp_acc > MAX_CODE ||
              (cp_acc >= SURR_LO && cp_acc <= SURR_HI)) begin
            bad_seen = 1'b1;
          end
          cp_acc = '0;
          seq_min = MIN_NONE;
        end
      end
    end
    if (fin) begin
      if (cont_left != 2'd0) begin
        bad_seen = 1'b1;
      end
      verdict_q.push_back(!bad_seen);
      cont_left = 2'd0;
      cp_acc = '0;
      seq_min = MIN_NONE;
      bad_seen = 1'b0;
    end
  endtask

  // Sender: present the next byte at the falling edge once the previous one is gone
  always @(negedge clk) begin
    byte_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = byte_q.pop_front();
        in_valid <= 1'b1;
        data_byte <= nxt.val;
        last_byte <= nxt.fin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_reqs) begin
      out_ready <= 1'b0;
      hold_taken <= hold_taken + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on input transfers, check output transfers
  always @(posedge clk) begin
    logic want;
    in_taken <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      judge_byte(data_byte, last_byte);
    end
    if (!rst && out_valid && out_ready) begin
      verdicts_seen++;
      if (string_valid === 1'b1) begin
        valid_seen++;
      end
      if (verdict_q.size() == 0) begin
        flag_error($sformatf("verdict %0d: string_valid=%b with no string pending",
                             verdicts_seen, string_valid));
      end else begin
        want = verdict_q.pop_front();
        if (string_valid !== want) begin
          flag_error($sformatf("verdict %0d: string_valid expected %b got %b",
                               verdicts_seen, want, string_valid));
        end
      end
    end
  end

  task automatic put_byte(input logic [7:0] b);
    str_buf.push_back(b);
  endtask

  // Encode cp into exactly len bytes; short values give overlong forms.
  task automatic put_cp(input logic [20:0] cp, input int len);
    case (len)
      1: put_byte({1'b0, cp[6:0]});
      2: begin
        put_byte({3'b110, cp[10:6]});
        put_byte({2'b10, cp[5:0]});
      end
      3: begin
        put_byte({4'b1110, cp[15:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end
      default: begin
        put_byte({5'b11110, cp[20:18]});
        put_byte({2'b10, cp[17:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  function automatic logic [20:0] pick_cp(input int len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range(8'h7F, 1));
      2: cp = 21'($urandom_range(11'h7FF, 8'h80));
      3: begin
        cp = 21'($urandom_range(16'hFFFF, 12'h800));
        // step over the surrogate block
        if (cp >= SURR_LO && cp <= SURR_HI) begin
          cp = cp + 21'h000800;
        end
      end
      default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
    endcase
    return cp;
  endfunction

  task automatic put_valid_cps(input int n);
    int len;
    repeat (n) begin
      len = $urandom_range(4, 1);
      put_cp(pick_cp(len), len);
    end
  endtask

  task automatic ship_string();
    byte_item_t it;
    for (int i = 0; i < str_buf.size(); i++) begin
      it.val = str_buf[i];
      it.fin = (i == str_buf.size() - 1);
      byte_q.push_back(it);
    end
    bytes_queued += str_buf.size();
    strings_queued++;
    str_buf.delete();
  endtask

  // Up to four bytes, most significant first
  task automatic directed_str(input logic [31:0] bytes, input int n);
    for (int i = n - 1; i >= 0; i--) begin
      put_byte(bytes[8*i +: 8]);
    end
    ship_string();
  endtask

  task automatic gen_strings(input int n_bytes);
    int start;
    int kind;
    int len;
    start = bytes_queued;
    while (bytes_queued - start < n_bytes) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        put_valid_cps($urandom_range(6, 1));
      end else if (kind < 78) begin
        // end the string inside a multi-byte sequence
        put_valid_cps($urandom_range(2, 0));
        len = $urandom_range(4, 2);
        put_cp(pick_cp(len), len);
        repeat ($urandom_range(len - 1, 1)) void'(str_buf.pop_back());
      end else if (kind < 84) begin
        put_valid_cps($urandom_range(2, 0));
        len = $urandom_range(4, 2);
        put_cp(21'($urandom_range(seq_floor(2'(len - 1)) - 1, 0)), len);
        put_valid_cps($urandom_range(2, 0));
      end else if (kind < 88) begin
        put_valid_cps($urandom_range(2, 0));
        put_cp(21'($urandom_range(16'hDFFF, 16'hD800)), 3);
        put_valid_cps($urandom_range(2, 0));
      end else if (kind < 91) begin
        put_valid_cps($urandom_range(2, 0));
        put_cp(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
        put_valid_cps($urandom_range(2, 0));
      end else begin
        repeat ($urandom_range(8, 1)) put_byte(8'($urandom_range(255)));
      end
      ship_string();
    end
  endtask

  // Hold until every byte is transferred and every verdict checked
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    @(posedge clk);
    send_idle_pct = 25;
    recv_idle_pct = 71;
    directed_str(32'h41, 1);          // plain ASCII
    directed_str(32'h00, 1);          // NUL lead
    directed_str(32'h80, 1);          // continuation as lead
    directed_str(32'hFF, 1);          // 11111xxx lead
    directed_str(32'hC280, 2);        // smallest two-byte value
    directed_str(32'hC1BF, 2);        // overlong two-byte
    directed_str(32'hE0, 1);          // truncated three-byte
    directed_str(32'hEDA080, 3);      // surrogate
    directed_str(32'hF48FBFBF, 4);    // largest code point
    directed_str(32'hF4908080, 4);    // above the code space
    directed_str(32'hC34142, 3);      // missing continuation, rest absorbed
    directed_str(32'hC300, 2);        // NUL where a continuation belongs
    gen_strings(250);
    wait_drained();

    @(posedge clk);
    send_idle_pct = 71;
    recv_idle_pct = 25;
    gen_strings(275);
    wait_drained();

    @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_reqs++;
    // short strings back to back fill the queue during the hold
    repeat (40) begin
      put_byte(8'($urandom_range(8'h7F, 1)));
      ship_string();
    end
    gen_strings(240);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (verdict_q.size() != 0) begin
      flag_error($sformatf("%0d verdicts never arrived", verdict_q.size()));
    end
    $display("run: %0d bytes in %0d strings, %0d verdicts (%0d well-formed), %0d errors",
             bytes_queued, strings_queued, verdicts_seen, valid_seen, err_cnt);
    $display("run: idle mixes 25/71, 71/25 and none, plus a %0d-cycle receiver hold",
             HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
